### rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

   // Width of every port field.
   localparam int FIELD_WIDTH = 32;

   // Default number of low field bits that take part in the computation.
   localparam int OPERAND_WIDTH_DEFAULT = 32;

endpackage

`default_nettype wire

### rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation, right to left binary method
// Computes base ** exponent mod modulus with bit-serial modular multipliers.
//
// Usage:
//   Drive req_base, req_exponent and req_modulus and raise start. The item
//   is transferred at a rising edge where start is high and busy is low.
//   busy stays high while the item is worked on. The result appears on
//   rsp_power_result, marked by rsp_valid, which is high for exactly one
//   cycle; the receiver cannot stall, so it must take the result in that
//   cycle. Only the low OPERAND_WIDTH bits of each field are used.
//
// Operation:
//   The base is first reduced by the modulus, one bit per cycle. Each
//   exponent bit up to the highest set one is then handled by a square and
//   a multiply that run side by side, each consuming one multiplier bit
//   per cycle. rsp_valid rises and busy falls at the same edge; the result
//   and the next item can transfer at the edge after that. No new item is
//   taken until the last is done. A zero modulus answers 0 in the next
//   cycle and leaves busy low.
// Reset clears the control state; no item is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation #(
   parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [mexp_pkg::FIELD_WIDTH-1:0] req_base,
   input  wire logic [mexp_pkg::FIELD_WIDTH-1:0] req_exponent,
   input  wire logic [mexp_pkg::FIELD_WIDTH-1:0] req_modulus,
   output logic                                  rsp_valid,
   output logic [mexp_pkg::FIELD_WIDTH-1:0]      rsp_power_result
);

   localparam int W     = OPERAND_WIDTH;
   localparam int FW    = mexp_pkg::FIELD_WIDTH;
   localparam int CNT_W = $clog2(W);

   localparam logic [W-1:0]     ONE      = W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_REDUCE = 3'b010,
      ST_MUL    = 3'b100
   } state_type;

   // One step of interleaved modular multiplication: (2p + bit * addend) mod m,
   // valid for p < m and addend <= m.
   function automatic logic [W-1:0] mod_step(input logic [W-1:0] p,
                                             input logic [W-1:0] addend,
                                             input logic         bit_in,
                                             input logic [W-1:0] m);
      logic [W+1:0] t;
      logic [W+1:0] m1;
      logic [W+1:0] m2;
      logic [W+1:0] r;
      begin
         t  = {1'b0, p, 1'b0} + (bit_in ? {2'b00, addend} : {(W+2){1'b0}});
         m1 = {2'b00, m};
         m2 = {1'b0, m, 1'b0};
         if (t >= m2) begin
            r = t - m2;
         end else if (t >= m1) begin
            r = t - m1;
         end else begin
            r = t;
         end
         return r[W-1:0];
      end
   endfunction

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     sh_ff, sh_in;
   logic [W-1:0]     e_ff, e_in;
   logic [W-1:0]     m_ff, m_in;
   logic [W-1:0]     b_ff, b_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic [W-1:0]     pa_ff, pa_in;
   logic [W-1:0]     ps_ff, ps_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]    rsp_result_ff, rsp_result_in;

   logic [W-1:0]     sq_add;
   logic [W-1:0]     step_acc;
   logic [W-1:0]     step_sq;
   logic [W-1:0]     acc_next;
   logic [W-1:0]     e_next;

   assign sq_add   = (state_ff == ST_REDUCE) ? ONE : b_ff;
   assign step_acc = mod_step(pa_ff, acc_ff, sh_ff[W-1], m_ff);
   assign step_sq  = mod_step(ps_ff, sq_add, sh_ff[W-1], m_ff);
   assign acc_next = e_ff[0] ? step_acc : acc_ff;
   assign e_next   = e_ff >> 1;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      sh_in         = sh_ff;
      e_in          = e_ff;
      m_in          = m_ff;
      b_in          = b_ff;
      acc_in        = acc_ff;
      pa_in         = pa_ff;
      ps_in         = ps_ff;
      rsp_valid_in  = 1'b0;
      rsp_result_in = rsp_result_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sh_in  = req_base[W-1:0];
               e_in   = req_exponent[W-1:0];
               m_in   = req_modulus[W-1:0];
               ps_in  = '0;
               cnt_in = CNT_LAST;
               if (req_modulus[W-1:0] == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = '0;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            ps_in  = step_sq;
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff - CNT_ONE;
            if (cnt_ff == '0) begin
               b_in   = step_sq;
               acc_in = ONE;
               sh_in  = step_sq;
               pa_in  = '0;
               ps_in  = '0;
               cnt_in = CNT_LAST;
               if (e_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = FW'(ONE);
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            pa_in  = step_acc;
            ps_in  = step_sq;
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff - CNT_ONE;
            if (cnt_ff == '0) begin
               acc_in = acc_next;
               b_in   = step_sq;
               e_in   = e_next;
               sh_in  = step_sq;
               pa_in  = '0;
               ps_in  = '0;
               cnt_in = CNT_LAST;
               if (e_next == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = FW'(acc_next);
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      sh_ff         <= sh_in;
      e_ff          <= e_in;
      m_ff          <= m_in;
      b_ff          <= b_in;
      acc_ff        <= acc_in;
      pa_ff         <= pa_in;
      ps_ff         <= ps_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;

endmodule

`default_nettype wire
